@@ hw/rtl/lslf_pkg.sv @@
package lslf_pkg;

  localparam int XW    = 10;
  localparam int SKW   = 16;
  localparam int NW    = 21;
  localparam int SXW   = 30;
  localparam int SXXW  = 40;
  localparam int HW    = 20;
  localparam int PRW   = 70;
  localparam int DENW  = 61;
  localparam int FRAC  = 16;
  localparam int DVW   = 87;
  localparam int RW    = 48;
  localparam int NPROD = 6;

  localparam int MAX_SAMPLES_DEF = 1048576;
  localparam int SKIP_PERIOD_DEF = 65536;

  typedef struct packed {
    logic [NW-1:0]   n;
    logic [SXW-1:0]  sx;
    logic [SXXW-1:0] sxx;
    logic [SXW-1:0]  sy;
    logic [SXXW-1:0] sxy;
  } snap_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DEN,
    B_MAG,
    B_LOAD,
    B_DIV,
    B_FIN,
    B_OUT
  } bstate_t;

endpackage

@@ hw/rtl/lslf_front.sv @@
module lslf_front #(
  parameter int MaxSamples = lslf_pkg::MAX_SAMPLES_DEF,
  parameter int SkipPeriod = lslf_pkg::SKIP_PERIOD_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [lslf_pkg::SKW-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [lslf_pkg::XW-1:0]  x_sample,
  input  logic [lslf_pkg::XW-1:0]  y_sample,
  input  logic                     last,
  output logic                     push_valid,
  input  logic                     push_ready,
  output lslf_pkg::snap_t          push_data
);
  import lslf_pkg::*;

  localparam int PW = (SkipPeriod > 1) ? $clog2(SkipPeriod) : 1;
  localparam int CW = $clog2(MaxSamples + 1);
  localparam logic [PW-1:0] POS_LAST = PW'(SkipPeriod - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MaxSamples);

  logic [SKW-1:0]  skip_len;
  logic [PW-1:0]   pos;
  logic [CW-1:0]   cnt;
  logic [SXW-1:0]  sx, sy;
  logic [SXXW-1:0] sxx, sxy;

  logic [PW-1:0]   skip_c;
  logic            take, accept;
  logic [CW-1:0]   cnt_next;
  logic [SXW-1:0]  sx_next, sy_next;
  logic [SXXW-1:0] sxx_next, sxy_next;
  logic [2*XW-1:0] xx, xy;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;
  assign accept    = in_valid && push_ready;

  always_comb begin
    if (21'(skip_len) > 21'(SkipPeriod - 1)) begin
      skip_c = POS_LAST;
    end else begin
      skip_c = PW'(skip_len);
    end
    take = (pos >= skip_c) && (cnt < CNT_MAX);
    xx   = x_sample * x_sample;
    xy   = x_sample * y_sample;
    cnt_next = cnt;
    sx_next  = sx;
    sy_next  = sy;
    sxx_next = sxx;
    sxy_next = sxy;
    if (take) begin
      cnt_next = cnt + CW'(1);
      sx_next  = sx + SXW'(x_sample);
      sy_next  = sy + SXW'(y_sample);
      sxx_next = sxx + SXXW'(xx);
      sxy_next = sxy + SXXW'(xy);
    end
  end

  assign push_valid    = accept && last;
  assign push_data.n   = NW'(cnt_next);
  assign push_data.sx  = sx_next;
  assign push_data.sy  = sy_next;
  assign push_data.sxx = sxx_next;
  assign push_data.sxy = sxy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_len <= '0;
      pos      <= '0;
      cnt      <= '0;
      sx       <= '0;
      sy       <= '0;
      sxx      <= '0;
      sxy      <= '0;
    end else begin
      if (cfg_valid) begin
        skip_len <= cfg_data;
      end
      if (accept) begin
        if (last) begin
          pos <= '0;
          cnt <= '0;
          sx  <= '0;
          sy  <= '0;
          sxx <= '0;
          sxy <= '0;
        end else begin
          pos <= (pos == POS_LAST) ? '0 : pos + PW'(1);
          cnt <= cnt_next;
          sx  <= sx_next;
          sy  <= sy_next;
          sxx <= sxx_next;
          sxy <= sxy_next;
        end
      end
    end
  end

endmodule

@@ hw/rtl/lslf_queue.sv @@
module lslf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lslf_pkg::snap_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lslf_pkg::snap_t pop_data
);
  import lslf_pkg::*;

  snap_t      mem [2];
  logic       wp, rp;
  logic [1:0] fill;
  logic       do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ hw/rtl/lslf_back.sv @@
module lslf_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  lslf_pkg::snap_t                pop_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [lslf_pkg::RW-1:0] intercept,
  output logic signed [lslf_pkg::RW-1:0] slope,
  output logic                           degenerate
);
  import lslf_pkg::*;

  localparam logic [DVW-1:0] POS_LIM = DVW'(48'h7FFF_FFFF_FFFF);
  localparam logic [DVW-1:0] NEG_LIM = DVW'(48'h8000_0000_0000);
  localparam logic [6:0]     DIV_LAST = 7'(DVW - 1);

  bstate_t state, state_next;

  snap_t           sn;
  logic [PRW-1:0]  prod [NPROD];
  logic [2:0]      idx;
  logic            half;
  logic [PRW-1:0]  lo_part;
  logic [DENW-1:0] den;
  logic            sel;
  logic            neg;
  logic [PRW-1:0]  mag;
  logic [DVW-1:0]  dvd, quo;
  logic [DENW-1:0] rem;
  logic [6:0]      step;
  logic [RW-1:0]   a0;

  logic [SXW-1:0]  op_a;
  logic [SXXW-1:0] op_b;
  logic [HW-1:0]   op_h;
  logic [SXW+HW-1:0] mul;
  logic [PRW-1:0]  pp, pq;
  logic [DENW:0]   rem_sh;
  logic            ge;
  logic [DVW-1:0]  sat_mag;
  logic [RW-1:0]   fit;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (idx)
      3'd0: begin op_a = SXW'(sn.n); op_b = sn.sxx; end
      3'd1: begin op_a = sn.sx;      op_b = SXXW'(sn.sx); end
      3'd2: begin op_a = sn.sy;      op_b = sn.sxx; end
      3'd3: begin op_a = sn.sx;      op_b = sn.sxy; end
      3'd4: begin op_a = SXW'(sn.n); op_b = sn.sxy; end
      default: begin op_a = sn.sx;   op_b = SXXW'(sn.sy); end
    endcase
    op_h = half ? op_b[SXXW-1:HW] : op_b[HW-1:0];
    mul  = op_a * op_h;
  end

  always_comb begin
    pp = sel ? prod[4] : prod[2];
    pq = sel ? prod[5] : prod[3];
    rem_sh = {rem, dvd[DVW-1]};
    ge = rem_sh >= {1'b0, den};
    if (neg) begin
      sat_mag = (quo > NEG_LIM) ? NEG_LIM : quo;
      fit     = RW'(~sat_mag + DVW'(1));
    end else begin
      sat_mag = (quo > POS_LIM) ? POS_LIM : quo;
      fit     = RW'(sat_mag);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (pop_valid) state_next = B_MUL;
      B_MUL:   if (half && idx == 3'(NPROD - 1)) state_next = B_DEN;
      B_DEN:   state_next = B_MAG;
      B_MAG:   state_next = (den == '0) ? B_OUT : B_LOAD;
      B_LOAD:  state_next = B_DIV;
      B_DIV:   if (step == DIV_LAST) state_next = B_FIN;
      B_FIN:   state_next = sel ? B_OUT : B_MAG;
      B_OUT:   if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state == B_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        sn   <= pop_data;
        idx  <= '0;
        half <= 1'b0;
        sel  <= 1'b0;
      end
      B_MUL: begin
        if (!half) begin
          lo_part <= PRW'(mul);
        end else begin
          prod[idx] <= lo_part + (PRW'(mul) << HW);
          idx <= idx + 3'd1;
        end
        half <= ~half;
      end
      B_DEN: den <= DENW'(prod[0] - prod[1]);
      B_MAG: begin
        neg <= pp < pq;
        mag <= (pp < pq) ? pq - pp : pp - pq;
        if (den == '0) begin
          a0 <= '0;
          quo <= '0;
        end
      end
      B_LOAD: begin
        dvd  <= (DVW'(mag) << FRAC) + DVW'(den >> 1);
        quo  <= '0;
        rem  <= '0;
        step <= '0;
      end
      B_DIV: begin
        dvd  <= dvd << 1;
        quo  <= {quo[DVW-2:0], ge};
        rem  <= ge ? DENW'(rem_sh - {1'b0, den}) : DENW'(rem_sh);
        step <= step + 7'd1;
      end
      B_FIN: begin
        if (!sel) a0 <= fit;
        sel <= 1'b1;
      end
      B_OUT: begin
        if (out_free) begin
          intercept  <= (den == '0) ? '0 : a0;
          slope      <= (den == '0) ? '0 : fit;
          degenerate <= (den == '0);
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/least_squares_line_fit.sv @@
// channel | signals                                      | role
// cfg     | cfg_valid cfg_ready cfg_data                 | skip_len write
// in      | in_valid in_ready x_sample y_sample last     | one sample word
// out     | out_valid out_ready intercept slope degenerate | one fit word per set
// Samples are taken one per cycle unless the queue is full; the accumulators update in that cycle.
// In the back end, a set's fit builds six products, each from two halves on one
// shared 30x20 multiplier, then runs two 87-step bit-serial divisions.
// A two-entry queue holds finished sets; input stalls only when it is full.
// Reset (rst, synchronous) clears sums, skip_len, queue and out_valid.
module least_squares_line_fit #(
  parameter int MAX_SAMPLES = lslf_pkg::MAX_SAMPLES_DEF,
  parameter int SKIP_PERIOD = lslf_pkg::SKIP_PERIOD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lslf_pkg::SKW-1:0]       cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lslf_pkg::XW-1:0]        x_sample,
  input  logic [lslf_pkg::XW-1:0]        y_sample,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [lslf_pkg::RW-1:0] intercept,
  output logic signed [lslf_pkg::RW-1:0] slope,
  output logic                           degenerate
);
  import lslf_pkg::*;

  snap_t push_data, pop_data;
  logic  push_valid, push_ready, pop_valid, pop_ready;

  lslf_front #(
    .MaxSamples(MAX_SAMPLES),
    .SkipPeriod(SKIP_PERIOD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_sample   (x_sample),
    .y_sample   (y_sample),
    .last       (last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lslf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lslf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .intercept  (intercept),
    .slope      (slope),
    .degenerate (degenerate)
  );

endmodule

@@ verif/least_squares_line_fit_tb.sv @@
module least_squares_line_fit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lslf_pkg::*;

  localparam int SKIP_PERIOD = SKIP_PERIOD_DEF;
  localparam int MAX_SAMPLES = MAX_SAMPLES_DEF;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [RW-1:0] icpt;
    logic signed [RW-1:0] slp;
    logic                 deg;
  } fit_t;

  typedef struct {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic          l;
    bit            typed;
    fit_t          fit;
  } row_t;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [SKW-1:0]       cfg_data = '0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [XW-1:0]        x_sample = '0;
  logic [XW-1:0]        y_sample = '0;
  logic                 last = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic signed [RW-1:0] intercept;
  logic signed [RW-1:0] slope;
  logic                 degenerate;

  least_squares_line_fit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_sample(x_sample), .y_sample(y_sample), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .intercept(intercept), .slope(slope), .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  // line-fit predictor state
  bit [63:0] skip_reg, acc_x, acc_xx, acc_y, acc_xy, acc_n, period_pos;
  fit_t      fit_q[$];
  int        errors = 0;
  int        words_in = 0;
  int        fits_seen = 0;
  int        degen_seen = 0;
  int        snd_idle = 0;
  int        rcv_idle = 0;
  bit        holdoff = 0;
  longint    cycles = 0;

  function automatic logic [RW-1:0] q16_quot(bit [127:0] p, bit [127:0] q,
                                             bit [63:0] den);
    bit         neg;
    bit [127:0] m;
    bit [127:0] quo;
    bit [RW-1:0] mag;
    neg = p < q;
    m = neg ? q - p : p - q;
    m = (m << FRAC) + (den >> 1);
    quo = m / den;
    if (neg) begin
      mag = (quo > 128'h800000000000) ? 48'h800000000000 : quo[RW-1:0];
      return ~mag + 1'b1;
    end
    return (quo > 128'h7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : quo[RW-1:0];
  endfunction

  function automatic bit absorb(logic [XW-1:0] x, logic [XW-1:0] y, logic l,
                                output fit_t r);
    bit [63:0] skip;
    bit [63:0] den;
    skip = (skip_reg > SKIP_PERIOD - 1) ? SKIP_PERIOD - 1 : skip_reg;
    if (period_pos >= skip && acc_n < MAX_SAMPLES) begin
      acc_x += x;
      acc_xx += x * x;
      acc_y += y;
      acc_xy += x * y;
      acc_n += 1;
    end
    period_pos += 1;
    if (period_pos >= SKIP_PERIOD) period_pos = 0;
    if (!l) return 0;
    den = acc_n * acc_xx - acc_x * acc_x;
    if (den == 0) begin
      r.icpt = 0;
      r.slp = 0;
      r.deg = 1;
    end else begin
      r.icpt = q16_quot(128'(acc_y) * acc_xx, 128'(acc_x) * acc_xy, den);
      r.slp = q16_quot(128'(acc_n) * acc_xy, 128'(acc_x) * acc_y, den);
      r.deg = 0;
    end
    acc_x = 0; acc_xx = 0; acc_y = 0; acc_xy = 0; acc_n = 0; period_pos = 0;
    return 1;
  endfunction

  // assumes caller sits just after a falling edge
  task automatic send_word(logic [XW-1:0] x, logic [XW-1:0] y, logic l,
                           bit typed = 0, fit_t tf = '{0, 0, 0});
    fit_t r;
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    x_sample = x;
    y_sample = y;
    last = l;
    do @(posedge clk); while (!in_ready);
    words_in++;
    if (absorb(x, y, l, r)) fit_q.push_back(typed ? tf : r);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain_out();
    wait (fit_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_skip(logic [SKW-1:0] v);
    drain_out();
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    skip_reg = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_sets(int n_words, int max_len);
    int  len;
    bit  flat;
    logic [XW-1:0] x0, x, y;
    int  sent;
    sent = 0;
    while (sent < n_words) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(max_len * 4, 1)
                                      : $urandom_range(max_len, 1);
      flat = $urandom_range(9) == 0;
      x0 = XW'($urandom);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0: x = 0;
          1: x = '1;
          default: x = XW'($urandom);
        endcase
        if (flat) x = x0;
        y = ($urandom_range(7) == 0) ? {XW{1'($urandom_range(1))}} : XW'($urandom);
        send_word(x, y, i == len - 1);
      end
      sent += len;
    end
  endtask

  always @(negedge clk)
    out_ready <= holdoff ? 1'b0 : ($urandom_range(99) >= rcv_idle);

  always @(posedge clk) begin
    fit_t e;
    if (!rst && out_valid && out_ready) begin
      if (fit_q.size() == 0) begin
        $error("fit word with none expected");
        errors++;
      end else begin
        e = fit_q.pop_front();
        fits_seen++;
        if (e.deg) degen_seen++;
        if (intercept !== e.icpt) begin
          $error("intercept exp %0d got %0d", e.icpt, intercept);
          errors++;
        end
        if (slope !== e.slp) begin
          $error("slope exp %0d got %0d", e.slp, slope);
          errors++;
        end
        if (degenerate !== e.deg) begin
          $error("degenerate exp %0d got %0d", e.deg, degenerate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("least_squares_line_fit_tb failed");
      $finish;
    end
  end

  row_t rows[$];

  initial begin
    rows = '{
      // one sample: no line
      '{10'd5, 10'd7, 1, 1, '{0, 0, 1}},
      // same x twice
      '{10'd3, 10'd1, 0, 0, '{0, 0, 0}},
      '{10'd3, 10'd9, 1, 1, '{0, 0, 1}},
      // y = 2x + 1
      '{10'd0, 10'd1, 0, 0, '{0, 0, 0}},
      '{10'd1, 10'd3, 1, 1, '{48'sd65536, 48'sd131072, 0}},
      // extremes on y = x
      '{10'd0, 10'd0, 0, 0, '{0, 0, 0}},
      '{10'd1023, 10'd1023, 1, 1, '{48'sd0, 48'sd65536, 0}},
      // y = 1023 - x
      '{10'd0, 10'd1023, 0, 0, '{0, 0, 0}},
      '{10'd1023, 10'd0, 1, 1, '{48'sd67043328, -48'sd65536, 0}},
      // predicted rows
      '{10'd1, 10'd2, 0, 0, '{0, 0, 0}},
      '{10'd4, 10'd1000, 0, 0, '{0, 0, 0}},
      '{10'd1023, 10'd5, 0, 0, '{0, 0, 0}},
      '{10'd512, 10'd512, 1, 0, '{0, 0, 0}},
      '{10'd682, 10'd341, 0, 0, '{0, 0, 0}},
      '{10'd341, 10'd682, 0, 0, '{0, 0, 0}},
      '{10'd7, 10'd3, 1, 0, '{0, 0, 0}},
      '{10'd2, 10'd0, 0, 0, '{0, 0, 0}},
      '{10'd5, 10'd1, 0, 0, '{0, 0, 0}},
      '{10'd9, 10'd1023, 1, 0, '{0, 0, 0}}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (rows[i]) send_word(rows[i].x, rows[i].y, rows[i].l, rows[i].typed,
                                rows[i].fit);

    snd_idle = 29;
    rcv_idle = 71;
    random_sets(140, 12);

    write_skip(16'd3);
    snd_idle = 71;
    rcv_idle = 29;
    random_sets(140, 12);

    // whole set inside the skip window
    write_skip(16'hFFFF);
    for (int i = 0; i < 6; i++) send_word(XW'($urandom), XW'($urandom), i == 5);

    write_skip(16'd1);
    snd_idle = 0;
    rcv_idle = 0;
    fork
      begin
        holdoff = 1;
        repeat (600) @(posedge clk);
        holdoff = 0;
      end
    join_none
    random_sets(40, 2);
    drain_out();
    random_sets(110, 12);

    write_skip(16'd0);
    random_sets(30, 8);

    drain_out();
    $display("%0d sample words, %0d fits checked (%0d degenerate), skip 0/1/3/max",
             words_in, fits_seen, degen_seen);
    if (errors == 0 && fit_q.size() == 0) begin
      $display("least_squares_line_fit_tb passed");
    end else begin
      $display("least_squares_line_fit_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/lslf_pkg.sv
hw/rtl/lslf_front.sv
hw/rtl/lslf_queue.sv
hw/rtl/lslf_back.sv
hw/rtl/least_squares_line_fit.sv
verif/least_squares_line_fit_tb.sv
